// ----- src/ftws_pkg.sv -----
// ----------------------------------------------------------------------------
// ftws_pkg
// Shared types and constants for the frame time window statistics block.
// ----------------------------------------------------------------------------
package ftws_pkg;

    localparam int IV_W     = 32;
    localparam int RATE_W   = 28;
    localparam int FT_W     = 21;
    localparam int TICK_W   = 13;
    localparam int WL_W     = 9;

    localparam int RATE_NUM  = 256000000;
    localparam int IV_MIN    = 2;
    localparam int IV_MAX    = 1999999;
    localparam int FT_FLOOR  = 1000;
    localparam int TICK_MAX  = 5120;
    localparam int LOW_DIV   = 100;
    localparam int WIN_MIN   = 16;
    localparam int WIN_RESET = 128;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDIV,
        S_PUSH,
        S_SWEEP,
        S_MUL,
        S_SUB,
        S_SQRT,
        S_JDIV,
        S_MDIV,
        S_TDIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_JIT,
        DIV_MEAN,
        DIV_TICK
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     div_go;
        t_div_sel div_sel;
        logic     push;
        logic     sweep_go;
        logic     mul;
        logic     sub;
        logic     sqrt_go;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic iv_ok;
        logic n_ge2;
        logic div_busy;
        logic div_done;
        logic sqrt_busy;
        logic sqrt_done;
        logic sweep_busy;
        logic sweep_done;
        logic out_free;
    } t_stat;

endpackage

// ----- src/ftws_div.sv -----
// ----------------------------------------------------------------------------
// ftws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ftws_div #(
    parameter int DW = 36,
    parameter int VW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);

    localparam int CNW = $clog2(DW + 1);

    logic           r_run;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0]  r_quo;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_div;
    logic [VW:0]    trial;
    logic           ge;
    logic           fin;

    assign fin   = r_run && (r_cnt == CNW'(DW));
    assign trial = {r_rem, r_quo[DW-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_go) begin
            r_run <= 1'b1;
        end else if (fin) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
            r_cnt <= '0;
        end else if (r_run && !fin) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? VW'(trial - {1'b0, r_div}) : trial[VW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_run;
    assign o_done = fin;
    assign o_quo  = r_quo;

endmodule

// ----- src/ftws_sqrt.sv -----
// ----------------------------------------------------------------------------
// ftws_sqrt
// Integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ftws_sqrt #(
    parameter int RW = 60
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [RW-1:0]   i_rad,
    output logic            o_busy,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);

    localparam int OW  = RW / 2;
    localparam int CNW = $clog2(OW + 1);

    logic           r_run;
    logic [CNW-1:0] r_cnt;
    logic [RW-1:0]  r_rad;
    logic [OW+1:0]  r_rem;
    logic [OW-1:0]  r_root;
    logic [OW+3:0]  t;
    logic [OW+3:0]  trial;
    logic           ge;
    logic           fin;

    assign fin   = r_run && (r_cnt == CNW'(OW));
    assign t     = {r_rem, r_rad[RW-1:RW-2]};
    assign trial = (OW+4)'({r_root, 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_go) begin
            r_run <= 1'b1;
        end else if (fin) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_run && !fin) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= ge ? (OW+2)'(t - trial) : t[OW+1:0];
            r_root <= {r_root[OW-2:0], ge};
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_run;
    assign o_done = fin;
    assign o_root = r_root;

endmodule

// ----- src/ftws_dp.sv -----
// ----------------------------------------------------------------------------
// ftws_dp
// Datapath: window memories, sweep accumulators, shared divider and root.
// ----------------------------------------------------------------------------
module ftws_dp #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ftws_pkg::WL_W-1:0]     i_cfg_wr_data,
    input  logic [ftws_pkg::IV_W-1:0]     i_in_interval_us,
    input  logic                          i_out_ready,
    input  ftws_pkg::t_cmd                i_cmd,
    output ftws_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output logic [ftws_pkg::RATE_W-1:0]   o_rate_q8,
    output logic [ftws_pkg::FT_W-1:0]     o_frame_time_us,
    output logic [ftws_pkg::FT_W-1:0]     o_jitter_us,
    output logic [ftws_pkg::RATE_W-1:0]   o_mean_rate_q8,
    output logic [ftws_pkg::RATE_W-1:0]   o_low_rate_q8,
    output logic [ftws_pkg::TICK_W-1:0]   o_ticks_q8
);

    localparam int RATE_W = ftws_pkg::RATE_W;
    localparam int FT_W   = ftws_pkg::FT_W;
    localparam int WL_W   = ftws_pkg::WL_W;
    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int CW     = $clog2(MAX_WINDOW + 1);
    localparam int S1W    = FT_W + AW;
    localparam int S2W    = 2 * FT_W + AW;
    localparam int RSW    = RATE_W + AW;
    localparam int NUMW   = CW + S2W;
    localparam int SQW    = NUMW + (NUMW % 2);
    localparam int ROOTW  = SQW / 2;
    localparam int DW     = (RSW > ROOTW) ? RSW : ROOTW;

    logic [RATE_W-1:0] mem_rt [MAX_WINDOW];
    logic [FT_W-1:0]   mem_ft [MAX_WINDOW];

    logic [WL_W-1:0]             r_wl;
    logic [CW-1:0]               r_fill;
    logic [AW-1:0]               r_slot;
    logic                        r_seen;
    logic [RATE_W-1:0]           r_last_rate;
    logic [FT_W-1:0]             r_last_ft;
    logic [FT_W-1:0]             r_last_jit;
    logic [FT_W-1:0]             r_iv;
    logic [RATE_W-1:0]           r_mean;
    logic [ftws_pkg::TICK_W-1:0] r_ticks;

    logic              r_sw_run;
    logic              r_sw_act;
    logic [AW-1:0]     r_sw_idx;
    logic              r_v1;
    logic              r_v2;
    logic [FT_W-1:0]   r_ft1;
    logic [RATE_W-1:0] r_rt1;
    logic [FT_W-1:0]   r_ft2;
    logic [RATE_W-1:0] r_rt2;
    logic [2*FT_W-1:0] r_sq2;
    logic [S1W-1:0]    r_s1;
    logic [S2W-1:0]    r_s2;
    logic [RSW-1:0]    r_rs;
    logic [RATE_W-1:0] r_min1;
    logic [RATE_W-1:0] r_min2;
    logic [NUMW-1:0]   r_ns2;
    logic [NUMW-1:0]   r_s1sq;
    logic [NUMW-1:0]   r_num;

    logic [WL_W-1:0]   len_w;
    logic [CW-1:0]     len_c;
    logic [AW-1:0]     slot_cur;
    logic [CW-1:0]     slot_inc;
    logic              iv_ok;
    logic              sw_done;
    logic [DW-1:0]     dvd;
    logic [FT_W-1:0]   dvs;
    logic              div_busy;
    logic              div_done;
    logic [DW-1:0]     quo;
    logic              sq_busy;
    logic              sq_done;
    logic [ROOTW-1:0]  root;
    logic [FT_W-1:0]   ft_floor;
    logic [RATE_W:0]   low_sum;
    logic [RATE_W-1:0] low_val;

    always_comb begin
        if (r_wl < WL_W'(ftws_pkg::WIN_MIN)) begin
            len_w = WL_W'(ftws_pkg::WIN_MIN);
        end else if (r_wl > WL_W'(MAX_WINDOW)) begin
            len_w = WL_W'(MAX_WINDOW);
        end else begin
            len_w = r_wl;
        end
    end
    assign len_c    = len_w[CW-1:0];
    assign slot_cur = (CW'(r_slot) >= len_c) ? '0 : r_slot;
    assign slot_inc = CW'(slot_cur) + 1'b1;

    assign iv_ok = r_seen
                && (i_in_interval_us >= ftws_pkg::IV_W'(ftws_pkg::IV_MIN))
                && (i_in_interval_us <= ftws_pkg::IV_W'(ftws_pkg::IV_MAX));

    // config, window bookkeeping, last values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl        <= WL_W'(ftws_pkg::WIN_RESET);
            r_fill      <= '0;
            r_slot      <= '0;
            r_seen      <= 1'b0;
            r_last_rate <= '0;
            r_last_ft   <= '0;
            r_last_jit  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wl   <= i_cfg_wr_data;
                r_fill <= '0;
                r_slot <= '0;
            end else if (i_cmd.push) begin
                r_slot <= (slot_inc >= len_c) ? '0 : slot_inc[AW-1:0];
                r_fill <= (r_fill < len_c) ? r_fill + 1'b1 : len_c;
            end
            if (i_cmd.accept) begin
                r_seen <= 1'b1;
            end
            if (div_done && i_cmd.div_sel == ftws_pkg::DIV_RATE) begin
                r_last_rate <= quo[RATE_W-1:0];
                r_last_ft   <= r_iv;
            end
            if (div_done && i_cmd.div_sel == ftws_pkg::DIV_JIT) begin
                r_last_jit <= quo[FT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_iv <= i_in_interval_us[FT_W-1:0];
        end
        if (div_done && i_cmd.div_sel == ftws_pkg::DIV_MEAN) begin
            r_mean <= quo[RATE_W-1:0];
        end
        if (div_done && i_cmd.div_sel == ftws_pkg::DIV_TICK) begin
            r_ticks <= (quo > DW'(ftws_pkg::TICK_MAX)) ?
                       ftws_pkg::TICK_W'(ftws_pkg::TICK_MAX) : quo[ftws_pkg::TICK_W-1:0];
        end
    end

    // window memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem_ft[slot_cur] <= r_last_ft;
            mem_rt[slot_cur] <= r_last_rate;
        end
        if (r_sw_act) begin
            r_ft1 <= mem_ft[r_sw_idx];
            r_rt1 <= mem_rt[r_sw_idx];
        end
    end

    // sweep: read, square, accumulate
    assign sw_done = r_sw_run && !r_sw_act && !r_v1 && !r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_run <= 1'b0;
            r_sw_act <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
        end else begin
            r_v1 <= r_sw_act;
            r_v2 <= r_v1;
            if (i_cmd.sweep_go) begin
                r_sw_run <= 1'b1;
                r_sw_act <= 1'b1;
            end else begin
                if (sw_done) begin
                    r_sw_run <= 1'b0;
                end
                if (r_sw_act && r_sw_idx == AW'(r_fill - 1'b1)) begin
                    r_sw_act <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_go) begin
            r_sw_idx <= '0;
            r_s1     <= '0;
            r_s2     <= '0;
            r_rs     <= '0;
            r_min1   <= '1;
            r_min2   <= '1;
        end else begin
            if (r_sw_act) begin
                r_sw_idx <= r_sw_idx + 1'b1;
            end
            if (r_v1) begin
                r_ft2 <= r_ft1;
                r_rt2 <= r_rt1;
                r_sq2 <= r_ft1 * r_ft1;
            end
            if (r_v2) begin
                r_s1 <= r_s1 + S1W'(r_ft2);
                r_s2 <= r_s2 + S2W'(r_sq2);
                r_rs <= r_rs + RSW'(r_rt2);
                if (r_rt2 < r_min1) begin
                    r_min2 <= r_min1;
                    r_min1 <= r_rt2;
                end else if (r_rt2 < r_min2) begin
                    r_min2 <= r_rt2;
                end
            end
        end
    end

    // variance numerator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_ns2  <= NUMW'(r_fill * r_s2);
            r_s1sq <= NUMW'(r_s1 * r_s1);
        end
        if (i_cmd.sub) begin
            r_num <= r_ns2 - r_s1sq;
        end
    end

    ftws_sqrt #(.RW(SQW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.sqrt_go),
        .i_rad   (SQW'(r_num)),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (root)
    );

    assign ft_floor = (r_last_ft < FT_W'(ftws_pkg::FT_FLOOR)) ?
                      FT_W'(ftws_pkg::FT_FLOOR) : r_last_ft;

    always_comb begin
        unique case (i_cmd.div_sel)
            ftws_pkg::DIV_RATE: begin
                dvd = DW'(ftws_pkg::RATE_NUM);
                dvs = r_iv;
            end
            ftws_pkg::DIV_JIT: begin
                dvd = DW'(root);
                dvs = FT_W'(r_fill);
            end
            ftws_pkg::DIV_MEAN: begin
                dvd = DW'(r_rs);
                dvs = FT_W'(r_fill);
            end
            default: begin
                dvd = DW'(ftws_pkg::RATE_NUM);
                dvs = ft_floor;
            end
        endcase
    end

    ftws_div #(.DW(DW), .VW(FT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (i_cmd.div_go),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (quo)
    );

    // k lowest rates, k is 1 or 2 over the window range
    assign low_sum = {1'b0, r_min1} + {1'b0, r_min2};
    assign low_val = (WL_W'(r_fill) >= WL_W'(2 * ftws_pkg::LOW_DIV)) ?
                     low_sum[RATE_W:1] : r_min1;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_rate_q8       <= r_last_rate;
            o_frame_time_us <= r_last_ft;
            o_jitter_us     <= r_last_jit;
            o_mean_rate_q8  <= r_mean;
            o_low_rate_q8   <= low_val;
            o_ticks_q8      <= r_ticks;
        end
    end

    always_comb begin
        o_stat.iv_ok      = iv_ok;
        o_stat.n_ge2      = r_fill >= CW'(2);
        o_stat.div_busy   = div_busy;
        o_stat.div_done   = div_done;
        o_stat.sqrt_busy  = sq_busy;
        o_stat.sqrt_done  = sq_done;
        o_stat.sweep_busy = r_sw_run;
        o_stat.sweep_done = sw_done;
        o_stat.out_free   = !o_out_valid || i_out_ready;
    end

endmodule

// ----- src/ftws_ctrl.sv -----
// ----------------------------------------------------------------------------
// ftws_ctrl
// Controller: sequences one word through rate, sweep, root and divisions.
// ----------------------------------------------------------------------------
module ftws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ftws_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output ftws_pkg::t_cmd  o_cmd
);

    ftws_pkg::t_state r_state;
    ftws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_sel = ftws_pkg::DIV_RATE;
        unique case (r_state)
            ftws_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_stat.iv_ok ? ftws_pkg::S_RDIV : ftws_pkg::S_PUSH;
                end
            end
            ftws_pkg::S_RDIV: begin
                o_cmd.div_sel = ftws_pkg::DIV_RATE;
                o_cmd.div_go  = !i_stat.div_busy;
                if (i_stat.div_done) begin
                    n_state = ftws_pkg::S_PUSH;
                end
            end
            ftws_pkg::S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state = ftws_pkg::S_SWEEP;
            end
            ftws_pkg::S_SWEEP: begin
                o_cmd.sweep_go = !i_stat.sweep_busy;
                if (i_stat.sweep_done) begin
                    n_state = i_stat.n_ge2 ? ftws_pkg::S_MUL : ftws_pkg::S_MDIV;
                end
            end
            ftws_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = ftws_pkg::S_SUB;
            end
            ftws_pkg::S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state = ftws_pkg::S_SQRT;
            end
            ftws_pkg::S_SQRT: begin
                o_cmd.sqrt_go = !i_stat.sqrt_busy;
                if (i_stat.sqrt_done) begin
                    n_state = ftws_pkg::S_JDIV;
                end
            end
            ftws_pkg::S_JDIV: begin
                o_cmd.div_sel = ftws_pkg::DIV_JIT;
                o_cmd.div_go  = !i_stat.div_busy;
                if (i_stat.div_done) begin
                    n_state = ftws_pkg::S_MDIV;
                end
            end
            ftws_pkg::S_MDIV: begin
                o_cmd.div_sel = ftws_pkg::DIV_MEAN;
                o_cmd.div_go  = !i_stat.div_busy;
                if (i_stat.div_done) begin
                    n_state = ftws_pkg::S_TDIV;
                end
            end
            ftws_pkg::S_TDIV: begin
                o_cmd.div_sel = ftws_pkg::DIV_TICK;
                o_cmd.div_go  = !i_stat.div_busy;
                if (i_stat.div_done) begin
                    n_state = ftws_pkg::S_OUT;
                end
            end
            ftws_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ftws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ftws_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/frame_time_window_statistics.sv -----
// ----------------------------------------------------------------------------
// frame_time_window_statistics
// Sliding-window frame rate, jitter, mean and low rate statistics.
// ----------------------------------------------------------------------------
// Input channel i_in_valid/o_in_ready carries one frame interval word in us.
// Output channel o_out_valid/i_out_ready returns one statistics word per
// input word: rate, frame time, jitter, mean rate, low rate and ticks.
// i_cfg_wr_en/i_cfg_wr_data set the window length (clamped to 16..MAX_WINDOW)
// and empty the window; write it only while the block is idle.
// One word at a time. Between the accepting edge and o_out_valid lie four
// passes through the shared radix-2 divider, a bit-serial square root and
// a sweep of the window memories over the window fill (at most MAX_WINDOW =
// 256). An invalid interval, or the first word after reset, skips the rate
// division; a fill below two skips the root and the jitter division. A new
// word is taken only once the last one is through; o_in_ready is high only
// between words.
// The result waits in the output register; if the receiver stalls, the
// block finishes the next word and holds it until that register frees.
// Synchronous reset clears the window, the last values and the handshakes;
// window length returns to 128.
// ----------------------------------------------------------------------------
module frame_time_window_statistics #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ftws_pkg::WL_W-1:0]     i_cfg_wr_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ftws_pkg::IV_W-1:0]     i_in_interval_us,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ftws_pkg::RATE_W-1:0]   o_rate_q8,
    output logic [ftws_pkg::FT_W-1:0]     o_frame_time_us,
    output logic [ftws_pkg::FT_W-1:0]     o_jitter_us,
    output logic [ftws_pkg::RATE_W-1:0]   o_mean_rate_q8,
    output logic [ftws_pkg::RATE_W-1:0]   o_low_rate_q8,
    output logic [ftws_pkg::TICK_W-1:0]   o_ticks_q8
);

    ftws_pkg::t_cmd  cmd;
    ftws_pkg::t_stat stat;

    ftws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ftws_dp #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_interval_us (i_in_interval_us),
        .i_out_ready      (i_out_ready),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_rate_q8        (o_rate_q8),
        .o_frame_time_us  (o_frame_time_us),
        .o_jitter_us      (o_jitter_us),
        .o_mean_rate_q8   (o_mean_rate_q8),
        .o_low_rate_q8    (o_low_rate_q8),
        .o_ticks_q8       (o_ticks_q8)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again before word finished");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("result load lost");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.div_busy && stat.sqrt_busy))
        else $error("divider and root active together");

endmodule

// ----- sim/tb_frame_time_window_statistics.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_time_window_statistics
// Self-checking bench for the sliding-window frame statistics block: an
// in-bench predictor computes each statistics word; a checker compares every
// returned word with the oldest prediction. Window length is swept.
// ----------------------------------------------------------------------------
module tb_frame_time_window_statistics;

    typedef struct packed {
        logic [ftws_pkg::RATE_W-1:0] rate;
        logic [ftws_pkg::FT_W-1:0]   ft;
        logic [ftws_pkg::FT_W-1:0]   jit;
        logic [ftws_pkg::RATE_W-1:0] mean;
        logic [ftws_pkg::RATE_W-1:0] low;
        logic [ftws_pkg::TICK_W-1:0] ticks;
    } t_stats;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [ftws_pkg::WL_W-1:0]   i_cfg_wr_data = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [ftws_pkg::IV_W-1:0]   i_in_interval_us = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [ftws_pkg::RATE_W-1:0] o_rate_q8;
    logic [ftws_pkg::FT_W-1:0]   o_frame_time_us;
    logic [ftws_pkg::FT_W-1:0]   o_jitter_us;
    logic [ftws_pkg::RATE_W-1:0] o_mean_rate_q8;
    logic [ftws_pkg::RATE_W-1:0] o_low_rate_q8;
    logic [ftws_pkg::TICK_W-1:0] o_ticks_q8;

    frame_time_window_statistics dut (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor state
    logic [ftws_pkg::FT_W-1:0]   ft_win [256];
    logic [ftws_pkg::RATE_W-1:0] rate_win [256];
    int unsigned                 fill_n, slot, win_len;
    bit                          seen_first;
    logic [ftws_pkg::RATE_W-1:0] prev_rate;
    logic [ftws_pkg::FT_W-1:0]   prev_ft;
    logic [ftws_pkg::FT_W-1:0]   prev_jit;

    t_stats expected_q [$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     stall_enable = 1'b1;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_stats predict_stats(logic [ftws_pkg::IV_W-1:0] iv);
        t_stats s;
        longint unsigned s1, s2, rsum, lsum, ft;
        int unsigned k, m, t;
        logic [ftws_pkg::RATE_W-1:0] srt [256];
        s1 = 0; s2 = 0; rsum = 0; lsum = 0;
        if (seen_first) begin
            if (iv >= ftws_pkg::IV_MIN && iv <= ftws_pkg::IV_MAX) begin
                prev_rate = ftws_pkg::RATE_W'(ftws_pkg::RATE_NUM / iv);
                prev_ft   = iv[ftws_pkg::FT_W-1:0];
            end
        end else begin
            seen_first = 1'b1;
        end
        if (slot >= win_len) slot = 0;
        ft_win[slot]   = prev_ft;
        rate_win[slot] = prev_rate;
        slot = (slot + 1 >= win_len) ? 0 : slot + 1;
        if (fill_n < win_len) fill_n++;
        for (int i = 0; i < fill_n; i++) begin
            s1 += ft_win[i];
            s2 += longint'(ft_win[i]) * ft_win[i];
            rsum += rate_win[i];
            srt[i] = rate_win[i];
        end
        if (fill_n >= 2)
            prev_jit = ftws_pkg::FT_W'(isqrt(longint'(fill_n) * s2 - s1 * s1) / fill_n);
        k = fill_n / ftws_pkg::LOW_DIV;
        if (k < 1) k = 1;
        for (int i = 0; i < k; i++) begin
            m = i;
            for (int j = i + 1; j < fill_n; j++)
                if (srt[j] < srt[m]) m = j;
            t = srt[i]; srt[i] = srt[m]; srt[m] = ftws_pkg::RATE_W'(t);
            lsum += srt[i];
        end
        ft = (prev_ft < ftws_pkg::FT_FLOOR) ? ftws_pkg::FT_FLOOR : prev_ft;
        ft = ftws_pkg::RATE_NUM / ft;
        s.rate  = prev_rate;
        s.ft    = prev_ft;
        s.jit   = prev_jit;
        s.mean  = ftws_pkg::RATE_W'(rsum / fill_n);
        s.low   = ftws_pkg::RATE_W'(lsum / k);
        s.ticks = (ft > ftws_pkg::TICK_MAX) ? ftws_pkg::TICK_W'(ftws_pkg::TICK_MAX)
                                            : ftws_pkg::TICK_W'(ft);
        return s;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 99) < 40) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    task automatic send_interval(logic [ftws_pkg::IV_W-1:0] iv);
        int g;
        g = stall_enable ? gap_len() : 0;
        repeat (g + 1) @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_in_interval_us <= iv;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.insert(expected_q.size(), predict_stats(iv));
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_window_len(logic [ftws_pkg::WL_W-1:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        win_len = (v < ftws_pkg::WIN_MIN) ? ftws_pkg::WIN_MIN : (v > 256 ? 256 : v);
        fill_n = 0;
        slot   = 0;
    endtask

    function automatic logic [ftws_pkg::IV_W-1:0] rand_interval();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(ftws_pkg::IV_MIN, 100000);
        if (r < 80) return $urandom_range(ftws_pkg::IV_MIN, ftws_pkg::IV_MAX);
        if (r < 88) return $urandom_range(0, 1);
        if (r < 94) return $urandom_range(ftws_pkg::IV_MAX + 1, 32'hFFFF_FFFF);
        return $urandom_range(990, 1010);
    endfunction

    task automatic test_directed();
        logic [ftws_pkg::IV_W-1:0] vals [20] = '{5, 2, 1999999, 0, 1, 2000000,
            32'hFFFF_FFFF, 16666, 999, 1000, 1001, 50000, 3, 32'hAAAA_AAAA,
            32'h5555_5555, 12500, 100, 1999998, 8333, 33333};
        foreach (vals[i]) send_interval(vals[i]);
    endtask

    task automatic test_random(int cnt);
        repeat (cnt) send_interval(rand_interval());
    endtask

    task automatic test_hold_off();
        drain();
        test_random(20);
    endtask

    task automatic test_window_lengths();
        write_window_len(9'd0);   test_random(40);
        write_window_len(9'd16);  test_random(30);
        write_window_len(9'h1FF); test_random(40);
        stall_enable = 1'b0;
        write_window_len(9'd256); test_random(280);
        stall_enable = 1'b1;
        write_window_len(9'd100); test_random(20);
        write_window_len(9'd17);  test_random(20);
    endtask

    // sink side stalls
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            g = gap_len();
            if (g != 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    end

    // checker
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word", $time);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (e != {o_rate_q8, o_frame_time_us, o_jitter_us, o_mean_rate_q8,
                          o_low_rate_q8, o_ticks_q8}) begin
                    $display("%0t: exp rate %0d ft %0d jit %0d mean %0d low %0d tk %0d",
                        $time, e.rate, e.ft, e.jit, e.mean, e.low, e.ticks);
                    $display("%0t: act rate %0d ft %0d jit %0d mean %0d low %0d tk %0d",
                        $time, o_rate_q8, o_frame_time_us, o_jitter_us,
                        o_mean_rate_q8, o_low_rate_q8, o_ticks_q8);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        win_len = ftws_pkg::WIN_RESET; fill_n = 0; slot = 0; seen_first = 0;
        prev_rate = '0; prev_ft = '0; prev_jit = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(110);
        test_hold_off();
        test_window_lengths();
        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
